// ===== sv/yuvds_pkg.sv =====
// ============================================================================
// yuvds_pkg
// Shared types and constants for the 4:4:4 to 4:2:0 chroma downsampler.
// ============================================================================
package yuvds_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 9;
    localparam int ADDR_W    = 25;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_HALF_WIDTH_DEF  = 2048;
    localparam int MAX_HALF_HEIGHT_DEF = 2048;

    localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = CFG_W'(320);
    localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = CFG_W'(240);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT  = CFG_IDX_W'(2);

    // output layout
    localparam logic FMT_I420 = 1'b0;
    localparam logic FMT_NV12 = 1'b1;

    // output queue of per-pixel records
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] luma_in;
        logic [PIX_W-1:0] cb_in;
        logic [PIX_W-1:0] cr_in;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [PIX_W-1:0]  byte_value;
        logic              last_of_item;
    } t_out;

    // all bytes caused by one pixel
    typedef struct packed {
        logic              three;
        logic [ADDR_W-1:0] y_addr;
        logic [PIX_W-1:0]  y_val;
        logic [ADDR_W-1:0] u_addr;
        logic [PIX_W-1:0]  u_val;
        logic [ADDR_W-1:0] v_addr;
        logic [PIX_W-1:0]  v_val;
    } t_rec;

    typedef enum logic [1:0] {
        SLOT_Y,
        SLOT_U,
        SLOT_V
    } t_slot;

endpackage

// ===== sv/yuvds_linebuf.sv =====
// ============================================================================
// yuvds_linebuf
// Line buffer of horizontal chroma pair sums, one write and one read port,
// registered read data.
// ============================================================================
module yuvds_linebuf #(
    parameter int MAX_HALF_WIDTH = yuvds_pkg::MAX_HALF_WIDTH_DEF,
    parameter int AW = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [2*yuvds_pkg::SUM_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [2*yuvds_pkg::SUM_W-1:0] o_rd_data
);

    logic [2*yuvds_pkg::SUM_W-1:0] r_mem [MAX_HALF_WIDTH];
    logic [2*yuvds_pkg::SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/yuvds_outq.sv =====
// ============================================================================
// yuvds_outq
// Small queue of per-pixel byte records and the serializer that sends them
// out one byte per transaction.
// ============================================================================
module yuvds_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  yuvds_pkg::t_rec               i_rec,
    output logic [yuvds_pkg::OQ_LVL_W-1:0] o_level,
    output logic                          o_valid,
    input  logic                          i_stall,
    output yuvds_pkg::t_out               o_data
);

    yuvds_pkg::t_rec                      r_q [yuvds_pkg::OQ_DEPTH];
    logic [yuvds_pkg::OQ_PTR_W-1:0]       r_wr_ptr;
    logic [yuvds_pkg::OQ_PTR_W-1:0]       r_rd_ptr;
    logic [yuvds_pkg::OQ_LVL_W-1:0]       r_level;
    yuvds_pkg::t_slot                     r_slot;
    yuvds_pkg::t_slot                     n_slot;
    yuvds_pkg::t_rec                      head;
    logic                                 take;
    logic                                 pop;

    assign head    = r_q[r_rd_ptr];
    assign o_valid = (r_level != '0);
    assign take    = o_valid && !i_stall;

    // next slot
    always_comb begin
        n_slot = r_slot;
        pop    = 1'b0;
        if (take) begin
            case (r_slot)
                yuvds_pkg::SLOT_Y: begin
                    if (head.three) begin
                        n_slot = yuvds_pkg::SLOT_U;
                    end else begin
                        pop = 1'b1;
                    end
                end
                yuvds_pkg::SLOT_U: n_slot = yuvds_pkg::SLOT_V;
                yuvds_pkg::SLOT_V: begin
                    n_slot = yuvds_pkg::SLOT_Y;
                    pop    = 1'b1;
                end
                default: n_slot = yuvds_pkg::SLOT_Y;
            endcase
        end
    end

    // byte selection
    always_comb begin
        case (r_slot)
            yuvds_pkg::SLOT_U: begin
                o_data.byte_address = head.u_addr;
                o_data.byte_value   = head.u_val;
                o_data.last_of_item = 1'b0;
            end
            yuvds_pkg::SLOT_V: begin
                o_data.byte_address = head.v_addr;
                o_data.byte_value   = head.v_val;
                o_data.last_of_item = 1'b1;
            end
            default: begin
                o_data.byte_address = head.y_addr;
                o_data.byte_value   = head.y_val;
                o_data.last_of_item = !head.three;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
            r_slot   <= yuvds_pkg::SLOT_Y;
        end else begin
            r_slot <= n_slot;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_rec;
        end
    end

    assign o_level = r_level;

endmodule

// ===== sv/yuv444_to_yuv420_downsampler.sv =====
// ============================================================================
// yuv444_to_yuv420_downsampler
// Packed 4:4:4 pixels in, 4:2:0 frame-buffer bytes (address + value) out.
// ============================================================================
// Path: an accepted pixel is registered in stage 1 and stage 2, then its record
//   is pushed into the output queue and its first byte goes out from there.
// Throughput: one pixel per cycle into the pipe while o_in_stall is low; the
//   output port moves one byte per cycle when not stalled, and a pixel gives
//   1 byte (luma only) or 3 bytes (second pixel of a pair on an odd row):
//   2 bytes per pixel on odd rows, 1.5 over a frame.
// Reset: counters and held chroma clear, sizes go to 640x480, layout I420;
//   the line buffer is not cleared and needs no clearing pass.
module yuv444_to_yuv420_downsampler #(
    parameter int MAX_HALF_WIDTH  = yuvds_pkg::MAX_HALF_WIDTH_DEF,
    parameter int MAX_HALF_HEIGHT = yuvds_pkg::MAX_HALF_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  yuvds_pkg::t_in                   i_in_data,
    // byte output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output yuvds_pkg::t_out                  o_out_data,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [yuvds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [yuvds_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int AD  = yuvds_pkg::ADDR_W;
    localparam int PW  = yuvds_pkg::PIX_W;
    localparam int SW  = yuvds_pkg::SUM_W;
    // clipped half sizes
    localparam int HWW = $clog2(MAX_HALF_WIDTH + 1);
    localparam int HHW = $clog2(MAX_HALF_HEIGHT + 1);
    // column / row counters (always below twice the max half size)
    localparam int CW  = $clog2(2 * MAX_HALF_WIDTH);
    localparam int RW  = $clog2(2 * MAX_HALF_HEIGHT);
    localparam int AW  = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
    localparam int CRW = yuvds_pkg::OQ_LVL_W + 1;

    // ------------------------------------------------------------------------
    // Configuration registers. Port is always ready; unknown index ignored.
    // ------------------------------------------------------------------------
    logic [yuvds_pkg::CFG_W-1:0] r_cfg_hw;
    logic [yuvds_pkg::CFG_W-1:0] r_cfg_hh;
    logic                        r_cfg_fmt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hw  <= yuvds_pkg::HALF_WIDTH_RST;
            r_cfg_hh  <= yuvds_pkg::HALF_HEIGHT_RST;
            r_cfg_fmt <= yuvds_pkg::FMT_I420;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                yuvds_pkg::CFG_HALF_WIDTH:  r_cfg_hw  <= i_cfg_data;
                yuvds_pkg::CFG_HALF_HEIGHT: r_cfg_hh  <= i_cfg_data;
                yuvds_pkg::CFG_OUT_FORMAT:  r_cfg_fmt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sizes: zero acts as one, anything above the max acts as the max. Config must
    // only change while idle, so these are stable; the block does not enforce it.
    logic [HWW-1:0] hw;
    logic [HHW-1:0] hh;
    logic [HWW:0]   w;
    logic [HHW:0]   h;
    logic [CW:0]    w_x;
    logic [RW:0]    h_x;

    always_comb begin
        if (r_cfg_hw == '0) begin
            hw = HWW'(1);
        end else if (32'(r_cfg_hw) > 32'(MAX_HALF_WIDTH)) begin
            hw = HWW'(MAX_HALF_WIDTH);
        end else begin
            hw = HWW'(r_cfg_hw);
        end
        if (r_cfg_hh == '0) begin
            hh = HHW'(1);
        end else if (32'(r_cfg_hh) > 32'(MAX_HALF_HEIGHT)) begin
            hh = HHW'(MAX_HALF_HEIGHT);
        end else begin
            hh = HHW'(r_cfg_hh);
        end
        w   = {hw, 1'b0};
        h   = {hh, 1'b0};
        w_x = (CW + 1)'(w);
        h_x = (RW + 1)'(h);
    end

    // ------------------------------------------------------------------------
    // Stage 0: position counters, held chroma, line buffer access.
    // ------------------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_held_cb;
    logic [PW-1:0] r_held_cr;

    logic [CW:0]   c_a;
    logic [RW:0]   r_a;
    logic [CW:0]   n_col_x;
    logic [RW:0]   n_row_x;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic [SW-1:0] sum_u;
    logic [SW-1:0] sum_v;
    logic          accept;
    logic          lb_wr;
    logic          lb_rd;
    logic [AW-1:0] lb_addr;

    logic [2*SW-1:0] lb_rd_data;

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        // fold counters left outside a shrunk frame
        c_a = {1'b0, r_col};
        r_a = {1'b0, r_row};
        if (c_a >= w_x) begin
            c_a = '0;
            r_a = r_a + 1'b1;
        end
        if (r_a >= h_x) begin
            r_a = '0;
        end
        col = c_a[CW-1:0];
        row = r_a[RW-1:0];

        n_col_x = {1'b0, col} + 1'b1;
        n_row_x = {1'b0, row};
        if (n_col_x >= w_x) begin
            n_col_x = '0;
            n_row_x = n_row_x + 1'b1;
            if (n_row_x >= h_x) begin
                n_row_x = '0;
            end
        end
    end

    assign sum_u   = {1'b0, r_held_cb} + {1'b0, i_in_data.cb_in};
    assign sum_v   = {1'b0, r_held_cr} + {1'b0, i_in_data.cr_in};
    assign lb_addr = AW'(col >> 1);
    // even row stores the pair sum; odd row fetches it a full row later,
    // so a write and a read of one entry never meet in flight
    assign lb_wr   = accept && col[0] && !row[0];
    assign lb_rd   = accept && col[0] && row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_held_cb <= '0;
            r_held_cr <= '0;
        end else if (accept) begin
            r_col <= n_col_x[CW-1:0];
            r_row <= n_row_x[RW-1:0];
            if (!col[0]) begin
                r_held_cb <= i_in_data.cb_in;
                r_held_cr <= i_in_data.cr_in;
            end
        end
    end

    yuvds_linebuf #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .AW             (AW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_wr_en   (lb_wr),
        .i_wr_addr (lb_addr),
        .i_wr_data ({sum_v, sum_u}),
        .i_rd_en   (lb_rd),
        .i_rd_addr (lb_addr),
        .o_rd_data (lb_rd_data)
    );

    // ------------------------------------------------------------------------
    // Stage 1: 2x2 averages from the stored sums, address products.
    // ------------------------------------------------------------------------
    logic          r1_valid;
    logic          r1_three;
    logic [PW-1:0] r1_y;
    logic [CW-1:0] r1_col;
    logic [RW-1:0] r1_row;
    logic [SW-1:0] r1_su;
    logic [SW-1:0] r1_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_three <= col[0] && row[0];
            r1_y     <= i_in_data.luma_in;
            r1_col   <= col;
            r1_row   <= row;
            r1_su    <= sum_u;
            r1_sv    <= sum_v;
        end
    end

    logic [SW:0]   su4;
    logic [SW:0]   sv4;
    logic [AD-1:0] crow;
    logic [AD-1:0] crow_mul;

    // four samples sum to at most 1020; (sum + 2) >> 2 rounds to nearest
    assign su4      = (SW + 1)'(lb_rd_data[SW-1:0]) + (SW + 1)'(r1_su) + (SW + 1)'(2);
    assign sv4      = (SW + 1)'(lb_rd_data[2*SW-1:SW]) + (SW + 1)'(r1_sv) + (SW + 1)'(2);
    assign crow     = AD'(r1_row >> 1);
    // chroma row pitch: half width for planar, full width for interleaved
    assign crow_mul = (r_cfg_fmt == yuvds_pkg::FMT_NV12) ? AD'(w) : AD'(hw);

    logic          r2_valid;
    logic          r2_three;
    logic [PW-1:0] r2_y;
    logic [PW-1:0] r2_u;
    logic [PW-1:0] r2_v;
    logic [CW-1:0] r2_col;
    logic [AD-1:0] r2_luma_row;
    logic [AD-1:0] r2_wh;
    logic [AD-1:0] r2_hwhh;
    logic [AD-1:0] r2_crow_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r2_three    <= r1_three;
            r2_y        <= r1_y;
            r2_u        <= su4[SW:2];
            r2_v        <= sv4[SW:2];
            r2_col      <= r1_col;
            r2_luma_row <= AD'(r1_row) * AD'(w);
            r2_wh       <= AD'(w) * AD'(h);
            r2_hwhh     <= AD'(hw) * AD'(hh);
            r2_crow_off <= crow * crow_mul;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: final byte addresses (mod 2^25), record into the queue.
    // ------------------------------------------------------------------------
    yuvds_pkg::t_rec rec;
    logic [AD-1:0]   col_a;
    logic [AD-1:0]   pair_a;
    logic [AD-1:0]   chroma_base;

    always_comb begin
        col_a       = AD'(r2_col);
        pair_a      = AD'(r2_col >> 1);
        chroma_base = r2_wh + r2_crow_off;

        rec.three  = r2_three;
        rec.y_addr = r2_luma_row + col_a;
        rec.y_val  = r2_y;
        rec.u_val  = r2_u;
        rec.v_val  = r2_v;
        if (r_cfg_fmt == yuvds_pkg::FMT_NV12) begin
            rec.u_addr = chroma_base + (col_a & ~AD'(1));
            rec.v_addr = chroma_base + (col_a | AD'(1));
        end else begin
            rec.u_addr = chroma_base + pair_a;
            rec.v_addr = chroma_base + r2_hwhh + pair_a;
        end
    end

    // ------------------------------------------------------------------------
    // Output queue. Input stalls when the queue plus the pixels in flight
    // could fill it, so the pipe itself never has to stop.
    // ------------------------------------------------------------------------
    logic [yuvds_pkg::OQ_LVL_W-1:0] oq_level;
    logic [CRW-1:0]                 credit_used;

    yuvds_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r2_valid),
        .i_rec   (rec),
        .o_level (oq_level),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    assign credit_used = CRW'(oq_level) + CRW'(r1_valid) + CRW'(r2_valid);
    assign o_in_stall  = (credit_used >= CRW'(yuvds_pkg::OQ_DEPTH));

endmodule

// ===== bench/tb_yuv444_to_yuv420_downsampler.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_yuv444_to_yuv420_downsampler
// Self-checking bench: random and directed pixel streams against a built-in
// model of the 4:2:0 subsampler. Covers frame-buffer addressing in both
// layouts, size changes in mid-frame, random idling and back-pressure.
// ============================================================================
module tb_yuv444_to_yuv420_downsampler;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 21;
    localparam int RANDOM_PIXELS = 340;
    localparam int DUT_LATENCY   = 3;
    localparam int HOLD_AT       = 60;      // pixels taken before the long output hold
    localparam int HOLD_CYCLES   = 300;
    localparam int CALM_FROM     = 220;     // window of pixels with no idling at all
    localparam int CALM_TO       = 300;
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam int PIX_W     = yuvds_pkg::PIX_W;
    localparam int SUM_W     = yuvds_pkg::SUM_W;
    localparam int ADDR_W    = yuvds_pkg::ADDR_W;
    localparam int CFG_W     = yuvds_pkg::CFG_W;
    localparam int CFG_IDX_W = yuvds_pkg::CFG_IDX_W;
    localparam int MAX_HW    = yuvds_pkg::MAX_HALF_WIDTH_DEF;
    localparam int MAX_HH    = yuvds_pkg::MAX_HALF_HEIGHT_DEF;

    // index that maps to no register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    logic                 pix_valid = 1'b0;
    yuvds_pkg::t_in       pix_data  = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    yuvds_pkg::t_out      out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    yuv444_to_yuv420_downsampler i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pix_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (pix_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // subsampler model: register copies, counters, line buffer of pair sums
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]     cfg_half_w = yuvds_pkg::HALF_WIDTH_RST;
    logic [CFG_W-1:0]     cfg_half_h = yuvds_pkg::HALF_HEIGHT_RST;
    logic                 cfg_fmt    = yuvds_pkg::FMT_I420;
    logic [2*SUM_W-1:0]   pair_sum     [MAX_HW];
    bit                   pair_written [MAX_HW];
    int unsigned          col_cnt    = 0;
    int unsigned          row_cnt    = 0;
    logic [PIX_W-1:0]     held_u     = '0;
    logic [PIX_W-1:0]     held_v     = '0;

    yuvds_pkg::t_in  pixel_queue[$];       // pixels waiting for the driver
    yuvds_pkg::t_out expected_bytes[$];    // bytes the DUT still owes, oldest first
    int   fails        = 0;
    int   pixels_taken = 0;
    logic calm;

    assign calm = (pixels_taken >= CALM_FROM) && (pixels_taken < CALM_TO);

    // zero acts as one, anything past the maximum acts as the maximum
    function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned max_v);
        if (v == 0)
            return 1;
        return (v > max_v) ? max_v : v;
    endfunction

    // Bytes caused by one pixel; updates the model state.
    function automatic void downsample_pixel(yuvds_pkg::t_in px);
        int unsigned     hw, hh, w, h, col, row, pair, su, sv, ua, va, base;
        yuvds_pkg::t_out b;
        hw = eff_size(cfg_half_w, MAX_HW);
        hh = eff_size(cfg_half_h, MAX_HH);
        w  = 2 * hw;
        h  = 2 * hh;
        // counters left outside a shrunken frame fold before the pixel
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
            row_cnt = 0;
        col  = col_cnt;
        row  = row_cnt;
        pair = col / 2;

        b.byte_address = ADDR_W'(row * w + col);
        b.byte_value   = px.luma_in;
        b.last_of_item = 1'b1;

        if (col % 2 == 0) begin
            held_u = px.cb_in;
            held_v = px.cr_in;
            expected_bytes.push_back(b);
        end else if (row % 2 == 0) begin
            su = held_u + px.cb_in;
            sv = held_v + px.cr_in;
            pair_sum[pair]     = {SUM_W'(sv), SUM_W'(su)};
            pair_written[pair] = 1'b1;
            expected_bytes.push_back(b);
        end else begin
            // second pixel of a pair on an odd row closes the 2x2 block
            su   = pair_sum[pair][SUM_W-1:0] + held_u + px.cb_in;
            sv   = pair_sum[pair][2*SUM_W-1:SUM_W] + held_v + px.cr_in;
            base = w * h;
            if (cfg_fmt == yuvds_pkg::FMT_I420) begin
                ua = base + hw * (row / 2) + pair;
                va = base + hw * hh + hw * (row / 2) + pair;
            end else begin
                ua = base + w * (row / 2) + 2 * pair;
                va = ua + 1;
            end
            b.last_of_item = 1'b0;
            expected_bytes.push_back(b);
            b.byte_address = ADDR_W'(ua);
            b.byte_value   = PIX_W'((su + 2) >> 2);
            expected_bytes.push_back(b);
            b.byte_address = ADDR_W'(va);
            b.byte_value   = PIX_W'((sv + 2) >> 2);
            b.last_of_item = 1'b1;
            expected_bytes.push_back(b);
        end

        col_cnt = col + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endfunction

    // A size change must never make an odd row read a pair sum that was
    // never stored. Only matters when the next pixel lands on an odd row.
    function automatic bit odd_row_reads_ok(logic [CFG_W-1:0] new_hw,
                                            logic [CFG_W-1:0] new_hh);
        int unsigned hw, w, h, col, row;
        hw  = eff_size(new_hw, MAX_HW);
        w   = 2 * hw;
        h   = 2 * eff_size(new_hh, MAX_HH);
        col = col_cnt;
        row = row_cnt;
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (row >= h)
            row = 0;
        if (row % 2 == 0)
            return 1'b1;
        for (int unsigned p = col / 2; p < hw; p++)
            if (!pair_written[p])
                return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic yuvds_pkg::t_in pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] u,
                                             logic [PIX_W-1:0] v);
        yuvds_pkg::t_in px;
        px.luma_in = y;
        px.cb_in   = u;
        px.cr_in   = v;
        return px;
    endfunction

    // sample with extra weight on the rails
    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // mostly tiny frames so odd rows come often; now and then medium,
    // zero, or at or beyond the maximum
    function automatic logic [CFG_W-1:0] pick_half_size(int unsigned small_max);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return CFG_W'($urandom_range(small_max, 1));
        if (r < 88)
            return CFG_W'($urandom_range(40, small_max + 1));
        if (r < 94)
            return '0;
        return CFG_W'($urandom_range(4095, 2048));
    endfunction

    // wait for the driver to run dry and every byte to come out
    task automatic drain();
        while (pixel_queue.size() != 0 || pix_valid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DUT_LATENCY + 1) @(negedge clk);
    endtask

    // one register transaction; only called with the block idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            yuvds_pkg::CFG_HALF_WIDTH:  cfg_half_w = value;
            yuvds_pkg::CFG_HALF_HEIGHT: cfg_half_h = value;
            yuvds_pkg::CFG_OUT_FORMAT:  cfg_fmt    = value[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // pixel driver: holds the payload while stalled, idles at random
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else if (!pix_valid || !in_stall) begin
            if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                pix_valid <= 1'b1;
                pix_data  <= pixel_queue.pop_front();
            end else begin
                pix_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output stall: random, plus one long hold while pixels keep coming so
    // the internal queue fills and the input side backs up
    // ------------------------------------------------------------------------
    int out_hold_left = 0;
    bit out_hold_done = 1'b0;

    always @(posedge clk) begin
        if (out_hold_left != 0) begin
            out_stall     <= 1'b1;
            out_hold_left <= out_hold_left - 1;
        end else if (!out_hold_done && pixels_taken >= HOLD_AT
                     && pixel_queue.size() >= 8) begin
            out_stall     <= 1'b1;
            out_hold_left <= HOLD_CYCLES;
            out_hold_done <= 1'b1;
        end else begin
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // scoreboard: check outgoing bytes first, then predict for the pixel
    // taken at this edge (a byte can never leave on its own input edge)
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        yuvds_pkg::t_out want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte: address %0d value %0d",
                           out_data.byte_address, out_data.byte_value);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_data.byte_address !== want.byte_address) begin
                        $error("byte_address expected %0d actual %0d",
                               want.byte_address, out_data.byte_address);
                        fails++;
                    end
                    if (out_data.byte_value !== want.byte_value) begin
                        $error("byte_value expected %0d actual %0d",
                               want.byte_value, out_data.byte_value);
                        fails++;
                    end
                    if (out_data.last_of_item !== want.last_of_item) begin
                        $error("last_of_item expected %0d actual %0d",
                               want.last_of_item, out_data.last_of_item);
                        fails++;
                    end
                end
            end
            if (pix_valid && !in_stall) begin
                downsample_pixel(pix_data);
                pixels_taken <= pixels_taken + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] new_hw, new_hh;
        int               n, tries, random_sent;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 2x2 frames; zero sizes act as one, dead index is ignored
        write_register(yuvds_pkg::CFG_HALF_WIDTH, '0);
        write_register(yuvds_pkg::CFG_HALF_HEIGHT, '0);
        write_register(yuvds_pkg::CFG_OUT_FORMAT, CFG_W'(yuvds_pkg::FMT_I420));
        write_register(CFG_UNUSED, '1);
        @(negedge clk);
        repeat (4) pixel_queue.push_back(pixel('1, '1, '1));
        pixel_queue.push_back(pixel('0, '0, '1));
        pixel_queue.push_back(pixel('1, '1, '0));
        pixel_queue.push_back(pixel('0, '0, '1));
        pixel_queue.push_back(pixel('1, '1, '0));
        drain();

        // same frame size, interleaved chroma
        write_register(yuvds_pkg::CFG_OUT_FORMAT, CFG_W'(yuvds_pkg::FMT_NV12));
        @(negedge clk);
        repeat (4) pixel_queue.push_back(pixel(rand_sample(), rand_sample(), rand_sample()));
        drain();

        // oversized frame: a few pixels of row 0 fill pair sums
        write_register(yuvds_pkg::CFG_HALF_WIDTH, '1);
        write_register(yuvds_pkg::CFG_HALF_HEIGHT, '1);
        @(negedge clk);
        repeat (6) pixel_queue.push_back(pixel(rand_sample(), rand_sample(), rand_sample()));
        drain();

        // narrow the frame mid-row: column folds, next row is odd and
        // closes blocks from the sums stored above; huge plane offsets
        write_register(yuvds_pkg::CFG_HALF_WIDTH, CFG_W'(2));
        write_register(yuvds_pkg::CFG_OUT_FORMAT, CFG_W'(yuvds_pkg::FMT_I420));
        @(negedge clk);
        repeat (4) pixel_queue.push_back(pixel(rand_sample(), rand_sample(), rand_sample()));
        drain();

        // shrink the height below the current row: row folds to 0
        write_register(yuvds_pkg::CFG_HALF_HEIGHT, CFG_W'(1));
        @(negedge clk);
        repeat (2) pixel_queue.push_back(pixel(rand_sample(), rand_sample(), rand_sample()));
        drain();

        // random phases, each with a fresh setting applied while idle
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            tries = 0;
            do begin
                new_hw = pick_half_size(6);
                new_hh = pick_half_size(4);
                tries++;
            end while (!odd_row_reads_ok(new_hw, new_hh) && tries < 8);
            if (!odd_row_reads_ok(new_hw, new_hh)) begin
                new_hw = cfg_half_w;
                new_hh = cfg_half_h;
            end
            write_register(yuvds_pkg::CFG_HALF_WIDTH, new_hw);
            write_register(yuvds_pkg::CFG_HALF_HEIGHT, new_hh);
            write_register(yuvds_pkg::CFG_OUT_FORMAT, CFG_W'($urandom_range(1)));
            if ($urandom_range(7) == 0)
                write_register(CFG_UNUSED, CFG_W'($urandom));
            @(negedge clk);
            n = $urandom_range(48, 8);
            repeat (n) pixel_queue.push_back(pixel(rand_sample(), rand_sample(), rand_sample()));
            random_sent += n;
            drain();
        end

        if (fails == 0 && expected_bytes.size() == 0)
            $display("yuv444_to_yuv420_downsampler regression: pass");
        else
            $display("yuv444_to_yuv420_downsampler regression: fail");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("yuv444_to_yuv420_downsampler regression: fail");
        $finish;
    end

endmodule
